// ----- rtl/fsksc_pkg.sv -----
// shared types, constants and register indices for the fsk subcarrier modulator
package fsksc_pkg;

    // fixed field widths
    localparam int BYTE_W     = 8;
    localparam int PERIOD_W   = 16;
    localparam int HALVES_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // parameter defaults
    localparam int TIMER_WIDTH_DEF   = 16;
    localparam int BITS_PER_BYTE_DEF = 8;

    // configuration register indices
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_ONE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_ZERO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALVES_ONE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HALVES_ZERO = 3'd4;

    // reset values
    localparam logic [PERIOD_W-1:0] PERIOD_ONE_RST  = 16'd499;
    localparam logic [PERIOD_W-1:0] PERIOD_ZERO_RST = 16'd293;
    localparam logic [HALVES_W-1:0] HALVES_ONE_RST  = 16'd100;
    localparam logic [HALVES_W-1:0] HALVES_ZERO_RST = 16'd170;

    // input function codes
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    typedef struct packed {
        logic                enable;
        logic [PERIOD_W-1:0] period_one;
        logic [PERIOD_W-1:0] period_zero;
        logic [HALVES_W-1:0] halves_one;
        logic [HALVES_W-1:0] halves_zero;
    } t_cfg;

    // side effects of writes to the enable register
    typedef struct packed {
        logic en_on;
        logic en_off;
    } t_cfg_evt;

    typedef struct packed {
        logic carrier_level;
        logic data_level;
        logic busy_res;
        logic byte_done;
        logic load_rejected;
    } t_result;

endpackage

// ----- rtl/fsk_subcarrier_byte_modulator.sv -----
// top level: request and result registers around the fsk modulator core
// a request is taken into the request register, and its core result enters the result
// register when that is free; throughput: one request per cycle while i_out_ready does
// not stall the result register, with the core state update between the two registers
// reset: synchronous active-low; clears control state and the configuration
// registers to their defaults, no clearing pass
module fsk_subcarrier_byte_modulator #(
    parameter int TIMER_WIDTH   = fsksc_pkg::TIMER_WIDTH_DEF,
    parameter int BITS_PER_BYTE = fsksc_pkg::BITS_PER_BYTE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_func,
    input  logic [fsksc_pkg::BYTE_W-1:0]       i_byte_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_carrier_level,
    output logic                               o_data_level,
    output logic                               o_busy_res,
    output logic                               o_byte_done,
    output logic                               o_load_rejected,
    input  logic                               i_cfg_we,
    input  logic [fsksc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fsksc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fsksc_pkg::*;

    logic              r_in_valid;
    logic              r_in_func;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    t_result           core_result;
    t_cfg              cfg;
    t_cfg_evt          cfg_evt;
    logic              fire;

    // pipeline handshake
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    fsksc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_evt       (cfg_evt)
    );

    fsksc_core #(
        .TIMER_WIDTH   (TIMER_WIDTH),
        .BITS_PER_BYTE (BITS_PER_BYTE)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_func       (r_in_func),
        .i_byte_value (r_in_byte),
        .i_cfg        (cfg),
        .i_evt        (cfg_evt),
        .o_result     (core_result)
    );

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_func <= i_func;
            r_in_byte <= i_byte_value;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_carrier_level = r_out.carrier_level;
    assign o_data_level    = r_out.data_level;
    assign o_busy_res      = r_out.busy_res;
    assign o_byte_done     = r_out.byte_done;
    assign o_load_rejected = r_out.load_rejected;

endmodule

// ----- rtl/fsksc_cfg_regs.sv -----
// configuration register file with enable write events
module fsksc_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fsksc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fsksc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output fsksc_pkg::t_cfg                    o_cfg,
    output fsksc_pkg::t_cfg_evt                o_evt
);
    import fsksc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_enable;

    // enable register write detection
    assign wr_enable    = i_cfg_we && (i_cfg_index == CFG_ENABLE);
    assign o_evt.en_on  = wr_enable && i_cfg_data[0] && !r_cfg.enable;
    assign o_evt.en_off = wr_enable && !i_cfg_data[0];
    assign o_cfg        = r_cfg;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLE:      n_cfg.enable      = i_cfg_data[0];
                CFG_PERIOD_ONE:  n_cfg.period_one  = PERIOD_W'(i_cfg_data);
                CFG_PERIOD_ZERO: n_cfg.period_zero = PERIOD_W'(i_cfg_data);
                CFG_HALVES_ONE:  n_cfg.halves_one  = HALVES_W'(i_cfg_data);
                CFG_HALVES_ZERO: n_cfg.halves_zero = HALVES_W'(i_cfg_data);
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable      <= 1'b0;
            r_cfg.period_one  <= PERIOD_ONE_RST;
            r_cfg.period_zero <= PERIOD_ZERO_RST;
            r_cfg.halves_one  <= HALVES_ONE_RST;
            r_cfg.halves_zero <= HALVES_ZERO_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- rtl/fsksc_core.sv -----
// subcarrier timer, bit serializer and per-request result logic
module fsksc_core #(
    parameter int TIMER_WIDTH   = fsksc_pkg::TIMER_WIDTH_DEF,
    parameter int BITS_PER_BYTE = fsksc_pkg::BITS_PER_BYTE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  logic                            i_func,
    input  logic [fsksc_pkg::BYTE_W-1:0]    i_byte_value,
    input  fsksc_pkg::t_cfg                 i_cfg,
    input  fsksc_pkg::t_cfg_evt             i_evt,
    output fsksc_pkg::t_result              o_result
);
    import fsksc_pkg::*;

    localparam int POS_W = (BITS_PER_BYTE > 1) ? $clog2(BITS_PER_BYTE) : 1;
    localparam int CMP_W = (TIMER_WIDTH > PERIOD_W) ? TIMER_WIDTH : PERIOD_W;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(BITS_PER_BYTE - 1);

    logic [TIMER_WIDTH-1:0] r_timer,   n_timer;
    logic                   r_carrier, n_carrier;
    logic [PERIOD_W-1:0]    r_period,  n_period;
    logic [HALVES_W-1:0]    r_halves,  n_halves;
    logic [POS_W-1:0]       r_pos,     n_pos;
    logic [BYTE_W-1:0]      r_shift,   n_shift;
    logic                   r_sending, n_sending;
    logic                   r_bit,     n_bit;

    logic                   is_load;
    logic [BYTE_W-1:0]      sel_byte;
    logic [POS_W-1:0]       sel_pos;
    logic [BYTE_W-1:0]      sel_shift;
    logic                   sel_bit;
    logic [PERIOD_W-1:0]    sel_period;
    logic [HALVES_W-1:0]    sel_halves_raw;
    logic [HALVES_W-1:0]    sel_halves;
    logic [TIMER_WIDTH-1:0] timer_next;
    logic                   half_event;
    logic [HALVES_W-1:0]    halves_dec;
    logic                   done;
    logic                   rejected;

    assign is_load = (i_func == FUNC_LOAD);

    // bit selection, shared by a fresh load and the step to the next bit
    assign sel_byte       = is_load ? i_byte_value : r_shift;
    assign sel_pos        = is_load ? LAST_POS : (r_pos - POS_W'(1));
    assign sel_shift      = sel_byte >> sel_pos;
    assign sel_bit        = sel_shift[0];
    assign sel_period     = sel_bit ? i_cfg.period_one : i_cfg.period_zero;
    assign sel_halves_raw = sel_bit ? i_cfg.halves_one : i_cfg.halves_zero;
    assign sel_halves     = (sel_halves_raw == '0) ? HALVES_W'(1) : sel_halves_raw;

    // timer advance and half-cycle detection
    assign timer_next = (CMP_W'(r_timer) >= CMP_W'(r_period)) ? '0
                      : (r_timer + TIMER_WIDTH'(1));
    assign half_event = (CMP_W'(timer_next) == CMP_W'(r_period));
    assign halves_dec = (r_halves != '0) ? (r_halves - HALVES_W'(1)) : r_halves;

    // next state
    always_comb begin
        n_timer   = r_timer;
        n_carrier = r_carrier;
        n_period  = r_period;
        n_halves  = r_halves;
        n_pos     = r_pos;
        n_shift   = r_shift;
        n_sending = r_sending;
        n_bit     = r_bit;
        done      = 1'b0;
        rejected  = 1'b0;
        if (i_fire) begin
            if (is_load) begin
                if (r_sending) begin
                    rejected = 1'b1;
                end else begin
                    n_shift   = i_byte_value;
                    n_pos     = LAST_POS;
                    n_sending = 1'b1;
                    n_bit     = sel_bit;
                    n_period  = sel_period;
                    n_halves  = sel_halves;
                end
            end else if (!i_cfg.enable) begin
                n_timer   = '0;
                n_carrier = 1'b0;
            end else begin
                n_timer = timer_next;
                if (half_event) begin
                    n_carrier = !r_carrier;
                    if (r_sending) begin
                        n_halves = halves_dec;
                        if (halves_dec == '0) begin
                            if (r_pos == '0) begin
                                n_sending = 1'b0;
                                done      = 1'b1;
                            end else begin
                                n_pos    = sel_pos;
                                n_bit    = sel_bit;
                                n_period = sel_period;
                                n_halves = sel_halves;
                            end
                        end
                    end
                end
            end
        end else begin
            if (i_evt.en_on && !r_sending) begin
                n_period = i_cfg.period_one;
                n_timer  = '0;
            end
            if (i_evt.en_off) begin
                n_timer   = '0;
                n_carrier = 1'b0;
            end
        end
    end

    assign o_result.carrier_level = n_carrier;
    assign o_result.data_level    = n_bit;
    assign o_result.busy_res      = n_sending;
    assign o_result.byte_done     = done;
    assign o_result.load_rejected = rejected;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer   <= '0;
            r_carrier <= 1'b0;
            r_period  <= PERIOD_ONE_RST;
            r_halves  <= '0;
            r_pos     <= '0;
            r_shift   <= '0;
            r_sending <= 1'b0;
            r_bit     <= 1'b0;
        end else begin
            r_timer   <= n_timer;
            r_carrier <= n_carrier;
            r_period  <= n_period;
            r_halves  <= n_halves;
            r_pos     <= n_pos;
            r_shift   <= n_shift;
            r_sending <= n_sending;
            r_bit     <= n_bit;
        end
    end

    // a finished byte leaves the serializer idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && done |=> !r_sending)
        else $error("byte done but serializer still busy");

    // a load is only rejected while a byte is in flight
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && rejected |-> r_sending)
        else $error("load rejected while idle");

    // a tick while disabled clears timer and carrier
    a_disabled_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_func == FUNC_TICK) && !i_cfg.enable |=> !r_carrier && (r_timer == '0))
        else $error("timer or carrier active while disabled");

    // an accepted load starts the serializer at the top bit
    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && is_load && !r_sending |=> r_sending && (r_pos == LAST_POS))
        else $error("load did not start at the top bit");

endmodule
